// File: hdl/spsm_pkg.sv
// Shared constants, types and command format for the stream pattern star masker.
package spsm_pkg;

    // Window and pattern geometry
    localparam int MAX_PATTERN = 16;
    localparam int WIN_IDX_W   = $clog2(MAX_PATTERN);
    localparam int CNT_W       = $clog2(MAX_PATTERN + 1);
    localparam int LEN_W       = 5;
    localparam int WORD_W      = 64;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd2;

    // Reset value of the pattern length register
    localparam logic [LEN_W-1:0] PATTERN_LENGTH_RESET = 5'd1;

    // Replacement byte for masked pattern bytes
    localparam logic [7:0] STAR_BYTE = 8'd42;

    // Default depth of the command queue between front and back
    localparam int FIFO_DEPTH = 4;

    typedef logic [7:0] byte_t;

    // One command: a window snapshot, how many leading results are stars,
    // how many results in all, and whether the final one closes the stream
    typedef struct packed {
        byte_t [MAX_PATTERN-1:0] bytes;
        logic  [CNT_W-1:0]       star_cnt;
        logic  [CNT_W-1:0]       total_cnt;
        logic                    eos;
    } cmd_t;

endpackage

// File: hdl/spsm_feed_if.sv
// Input byte stream channel.
interface spsm_feed_if import spsm_pkg::*; ();
    logic  valid;
    logic  ready;
    byte_t in_byte;
    logic  end_of_stream;

    modport source (output valid, output in_byte, output end_of_stream, input ready);
    modport sink   (input valid, input in_byte, input end_of_stream, output ready);
endinterface

// File: hdl/spsm_result_if.sv
// Output byte stream channel.
interface spsm_result_if import spsm_pkg::*; ();
    logic  valid;
    logic  ready;
    byte_t out_byte;
    logic  last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink   (input valid, input out_byte, input last, output ready);
endinterface

// File: hdl/spsm_cfg_if.sv
// Configuration write channel.
interface spsm_cfg_if import spsm_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [WORD_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/stream_pattern_star_masker_unit.sv
// Top level of the stream pattern star masker.
//
//  Channel   Direction  Transaction                    Payload
//  -------   ---------  -----------------------------  -----------------------
//  feed      in         one stream byte                in_byte, end_of_stream
//  result    out        one masked or passed byte      out_byte, last
//  cfg       in         one register write             index, data
//
// One byte is taken every cycle while the command queue has room; the back
// end gives one result per cycle while the receiver is ready, so a match or a
// flush of N bytes occupies the output for N results and the queue soaks these bursts up.
// The first result of a byte passes through the queue, then the output register.
// Reset empties the window and queue, drops the output register and returns
// the configuration registers to their reset values; cfg is always ready.
module stream_pattern_star_masker_unit import spsm_pkg::*;
#(
    parameter int FifoDepth = FIFO_DEPTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    spsm_feed_if.sink     feed,
    spsm_result_if.source result,
    spsm_cfg_if.sink      cfg
);

    logic push_valid;
    cmd_t push_cmd;
    logic push_ready;
    logic head_valid;
    cmd_t head;
    logic pop;

    // Classify bytes and issue commands
    spsm_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .feed       (feed),
        .cfg        (cfg),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .push_ready (push_ready)
    );

    // Decouple front and back
    spsm_cmd_fifo #(
        .Depth (FifoDepth)
    ) u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .push_ready (push_ready),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    // Expand commands into result bytes
    spsm_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .result     (result)
    );

endmodule

// File: hdl/spsm_front.sv
// Front end: configuration registers, byte window, match decision and command issue.
module spsm_front import spsm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    spsm_feed_if.sink   feed,
    spsm_cfg_if.sink    cfg,
    output logic        push_valid,
    output cmd_t        push_cmd,
    input  logic        push_ready
);

    logic [WORD_W-1:0]          pattern_low_reg;
    logic [WORD_W-1:0]          pattern_high_reg;
    logic [LEN_W-1:0]           pattern_length_reg;
    logic [CNT_W-1:0]           fill_reg;
    logic [CNT_W-1:0]           fill_next;
    byte_t [MAX_PATTERN-1:0]    win_reg;
    byte_t [MAX_PATTERN-1:0]    win_next;

    logic [2*WORD_W-1:0]        pattern_all;
    byte_t [MAX_PATTERN-1:0]    pat;
    byte_t [MAX_PATTERN-1:0]    app;
    logic [CNT_W-1:0]           eff_len;
    logic [CNT_W-1:0]           fill_app;
    logic [CNT_W-1:0]           shift;
    logic                       accept;
    logic                       decide;
    logic                       match;

    // Configuration writes are always taken
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            pattern_length_reg <= PATTERN_LENGTH_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_PATTERN_LOW:    pattern_low_reg    <= cfg.data;
                REG_PATTERN_HIGH:   pattern_high_reg   <= cfg.data;
                REG_PATTERN_LENGTH: pattern_length_reg <= cfg.data[LEN_W-1:0];
                default:            ;
            endcase
        end
    end

    // Clamp the pattern length to 1..MAX_PATTERN
    always_comb
    begin
        if (pattern_length_reg == '0)
            eff_len = CNT_W'(1);
        else if (pattern_length_reg > LEN_W'(MAX_PATTERN))
            eff_len = CNT_W'(MAX_PATTERN);
        else
            eff_len = CNT_W'(pattern_length_reg);
    end

    // Split the pattern into bytes
    assign pattern_all = {pattern_high_reg, pattern_low_reg};
    always_comb
    begin
        for (int i = 0; i < MAX_PATTERN; i++)
            pat[i] = pattern_all[8*i +: 8];
    end

    assign feed.ready = push_ready;
    assign accept     = feed.valid && push_ready;

    // Append the incoming byte behind the pending ones
    assign fill_app = (fill_reg < CNT_W'(MAX_PATTERN)) ? fill_reg + CNT_W'(1) : fill_reg;
    always_comb
    begin
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            if (CNT_W'(i) == fill_reg)
                app[i] = feed.in_byte;
            else
                app[i] = win_reg[i];
        end
    end

    // Compare the oldest eff_len bytes with the pattern
    assign decide = fill_app >= eff_len;
    always_comb
    begin
        match = 1'b1;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            if ((CNT_W'(i) < eff_len) && (app[i] != pat[i]))
                match = 1'b0;
        end
    end

    // Bytes that leave the window by the decision
    always_comb
    begin
        if (!decide)
            shift = '0;
        else if (match)
            shift = eff_len;
        else
            shift = CNT_W'(1);
    end

    // Issue a command for a decision or a flush
    always_comb
    begin
        push_valid         = accept && (decide || feed.end_of_stream);
        push_cmd.bytes     = app;
        push_cmd.star_cnt  = (decide && match) ? eff_len : '0;
        push_cmd.total_cnt = feed.end_of_stream ? fill_app : shift;
        push_cmd.eos       = feed.end_of_stream;
    end

    // Advance the window past the bytes handed on
    always_comb
    begin
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            logic [CNT_W:0] j;
            j = (CNT_W+1)'(i) + {1'b0, shift};
            if (j < (CNT_W+1)'(MAX_PATTERN))
                win_next[i] = app[j[WIN_IDX_W-1:0]];
            else
                win_next[i] = app[i];
        end
        fill_next = feed.end_of_stream ? '0 : fill_app - shift;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_reg <= '0;
        else if (accept)
            fill_reg <= fill_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            win_reg <= win_next;
    end

`ifndef SYNTHESIS
    a_fill_below_max: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg < CNT_W'(MAX_PATTERN))
        else $error("window fill reached its maximum after a step");

    a_flush_empties: assert property (@(posedge clk) disable iff (!rst_n)
        accept && feed.end_of_stream |=> fill_reg == '0)
        else $error("window not empty after end of stream");

    a_cmd_counts: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> (push_cmd.total_cnt != '0) && (push_cmd.star_cnt <= push_cmd.total_cnt))
        else $error("command with inconsistent result counts");
`endif

endmodule

// File: hdl/spsm_cmd_fifo.sv
// Short command queue between the front and back ends.
module spsm_cmd_fifo import spsm_pkg::*;
#(
    parameter int Depth = FIFO_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    input  cmd_t push_cmd,
    output logic push_ready,
    output logic head_valid,
    output cmd_t head,
    input  logic pop
);

    localparam int PtrW   = $clog2(Depth);
    localparam int CountW = $clog2(Depth + 1);

    cmd_t              entry_reg [Depth];
    logic [PtrW-1:0]   wr_ptr_reg;
    logic [PtrW-1:0]   rd_ptr_reg;
    logic [CountW-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = count_reg != CountW'(Depth);
    assign head_valid = count_reg != '0;
    assign head       = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    // Store a pushed command
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + PtrW'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + PtrW'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + CountW'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CountW'(1);
        end
    end

endmodule

// File: hdl/spsm_back.sv
// Back end: expands queued commands into result bytes through an output register.
module spsm_back import spsm_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          head_valid,
    input  cmd_t          head,
    output logic          pop,
    spsm_result_if.source result
);

    logic [WIN_IDX_W-1:0] idx_reg;
    logic                 out_valid_reg;
    byte_t                out_byte_reg;
    logic                 last_reg;
    logic                 load;
    logic                 is_final;
    byte_t                cur_byte;

    assign result.valid    = out_valid_reg;
    assign result.out_byte = out_byte_reg;
    assign result.last     = last_reg;

    // Load a new result whenever the output register is free or drained
    assign load     = head_valid && (!out_valid_reg || result.ready);
    assign is_final = ({1'b0, idx_reg} + CNT_W'(1)) == head.total_cnt;
    assign pop      = load && is_final;

    // Stars first, then window bytes from the same position
    assign cur_byte = ({1'b0, idx_reg} < head.star_cnt) ? STAR_BYTE : head.bytes[idx_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                idx_reg       <= is_final ? '0 : idx_reg + WIN_IDX_W'(1);
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the payload until the transaction completes
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg <= cur_byte;
            last_reg     <= head.eos && is_final;
        end
    end

endmodule

// File: sim/stream_pattern_star_masker_unit_tb.sv
// Self-checking testbench for the stream pattern star masker with a built-in masking predictor.
`timescale 1ns / 1ps

module stream_pattern_star_masker_unit_tb;
    import spsm_pkg::*;

    localparam int SETTLE_CYCLES = 6;
    localparam int STALL_LIMIT   = 2000;
    localparam int REPORT_MAX    = 10;

    typedef struct packed {
        byte_t data;
        logic  last;
    } masked_byte_t;

    logic clk = 1'b0;
    logic rst_n;

    spsm_feed_if   feed_ch ();
    spsm_result_if result_ch ();
    spsm_cfg_if    cfg_ch ();

    stream_pattern_star_masker_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .feed   (feed_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // Predictor state: pattern registers and pending window
    logic [2*WORD_W-1:0] pat_bits;
    logic [LEN_W-1:0]    pat_len;
    byte_t               win_bytes [MAX_PATTERN];
    int                  win_count;

    masked_byte_t masked_q [$];

    int send_idle_pct;
    int recv_idle_pct;
    int mismatches;
    int bytes_taken;
    int results_checked;
    int reg_writes;
    int stall_cycles;

    // Clock: 10 ns period
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int eff_len(input logic [LEN_W-1:0] code);
        int n;
        n = int'(code);
        if (n == 0)
            n = 1;
        if (n > MAX_PATTERN)
            n = MAX_PATTERN;
        return n;
    endfunction

    // Shift the window down by n bytes
    function automatic void window_drop(input int n);
        if (n >= win_count)
        begin
            win_count = 0;
            return;
        end
        for (int j = 0; j < win_count - n; j++)
            win_bytes[j] = win_bytes[j + n];
        win_count -= n;
    endfunction

    // Work out the masked bytes caused by one stream byte
    function automatic void mask_stream_byte(input byte_t b, input logic eos);
        int   plen;
        int   produced;
        logic hit;
        plen     = eff_len(pat_len);
        produced = 0;
        if (win_count < MAX_PATTERN)
        begin
            win_bytes[win_count] = b;
            win_count++;
        end
        if (win_count >= plen)
        begin
            hit = 1'b1;
            for (int i = 0; i < plen; i++)
                if (win_bytes[i] != pat_bits[8*i +: 8])
                    hit = 1'b0;
            if (hit)
            begin
                for (int i = 0; i < plen; i++)
                    masked_q.push_back('{data: STAR_BYTE, last: 1'b0});
                produced += plen;
                window_drop(plen);
            end
            else
            begin
                masked_q.push_back('{data: win_bytes[0], last: 1'b0});
                produced++;
                window_drop(1);
            end
        end
        // Flush the rest verbatim and mark the final byte
        if (eos)
        begin
            for (int i = 0; i < win_count; i++)
                masked_q.push_back('{data: win_bytes[i], last: 1'b0});
            produced += win_count;
            win_count = 0;
            if (produced > 0)
                masked_q[masked_q.size() - 1].last = 1'b1;
        end
    endfunction

    // Check results, then track writes and stream bytes, all on one edge
    always @(posedge clk)
    begin : channel_monitor
        masked_byte_t want;
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                results_checked++;
                if (masked_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("unexpected result: out_byte=%02h last=%0b",
                                 result_ch.out_byte, result_ch.last);
                end
                else
                begin
                    want = masked_q.pop_front();
                    if (result_ch.out_byte !== want.data || result_ch.last !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display("result %0d: out_byte exp %02h got %02h, last exp %0b got %0b",
                                     results_checked, want.data, result_ch.out_byte,
                                     want.last, result_ch.last);
                    end
                end
            end
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                reg_writes++;
                case (cfg_ch.index)
                    REG_PATTERN_LOW:    pat_bits[WORD_W-1:0]        = cfg_ch.data;
                    REG_PATTERN_HIGH:   pat_bits[2*WORD_W-1:WORD_W] = cfg_ch.data;
                    REG_PATTERN_LENGTH: pat_len                     = cfg_ch.data[LEN_W-1:0];
                    default: ;
                endcase
            end
            if (feed_ch.valid && feed_ch.ready)
            begin
                bytes_taken++;
                mask_stream_byte(feed_ch.in_byte, feed_ch.end_of_stream);
            end
        end
    end

    // Receiver back-pressure
    always @(posedge clk)
        result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

    // Watchdog on cycles with no transaction on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (feed_ch.valid && feed_ch.ready) || (result_ch.valid && result_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("timeout after %0d idle cycles, %0d results outstanding",
                     stall_cycles, masked_q.size());
            $display("tb: failure");
            $finish;
        end
    end

    // Offer one stream byte and hold it until taken
    task automatic send_byte(input byte_t b, input logic eos);
        while ($urandom_range(99) < send_idle_pct)
        begin
            feed_ch.valid <= 1'b0;
            @(posedge clk);
        end
        feed_ch.valid         <= 1'b1;
        feed_ch.in_byte       <= b;
        feed_ch.end_of_stream <= eos;
        @(posedge clk);
        while (!feed_ch.ready)
            @(posedge clk);
    endtask

    // Drop the feed and wait for every expected result plus the pipeline tail
    task automatic wait_idle();
        feed_ch.valid <= 1'b0;
        @(posedge clk);
        while (masked_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
    endtask

    task automatic load_pattern(input logic [2*WORD_W-1:0] bits, input logic [LEN_W-1:0] len);
        wait_idle();
        write_reg(REG_PATTERN_LOW, bits[WORD_W-1:0]);
        write_reg(REG_PATTERN_HIGH, bits[2*WORD_W-1:WORD_W]);
        write_reg(REG_PATTERN_LENGTH, WORD_W'(len));
        cfg_ch.valid <= 1'b0;
    endtask

    // Reset pattern is a single zero byte
    task automatic test_reset_defaults();
        send_byte(8'h00, 1'b0);
        send_byte(STAR_BYTE, 1'b0);
        send_byte(8'hFF, 1'b1);
    endtask

    // Widest pattern matched exactly, closed by end of stream
    task automatic test_full_length_match();
        logic [2*WORD_W-1:0] bits;
        bits = {64'h7E01_C324_9966_F00D, 64'hFF00_A55A_3C96_0F81};
        load_pattern(bits, LEN_W'(MAX_PATTERN));
        for (int i = 0; i < MAX_PATTERN; i++)
            send_byte(bits[8*i +: 8], i == MAX_PATTERN - 1);
    endtask

    // A length of zero behaves as one
    task automatic test_length_zero();
        load_pattern({64'h0, 64'h5A}, '0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h11, 1'b1);
    endtask

    // Shorten the pattern while the window still holds bytes
    task automatic test_length_change_midstream();
        load_pattern({64'h0, 64'h6463_6261}, 5'd4);
        send_byte(8'h61, 1'b0);
        send_byte(8'h62, 1'b0);
        send_byte(8'h63, 1'b0);
        wait_idle();
        write_reg(REG_PATTERN_LENGTH, WORD_W'(2));
        cfg_ch.valid <= 1'b0;
        send_byte(8'h64, 1'b0);
        send_byte(8'h65, 1'b1);
    endtask

    // Random bytes built mostly from whole and partial pattern occurrences
    task automatic run_stream_phase(input logic [LEN_W-1:0] len, input int n_bytes);
        logic [2*WORD_W-1:0] bits;
        int                  plen;
        int                  sent;
        int                  part;
        int                  kind;
        byte_t               b;
        bits = {$urandom, $urandom, $urandom, $urandom};
        plen = eff_len(len);
        load_pattern(bits, len);
        sent = 0;
        while (sent < n_bytes)
        begin
            kind = $urandom_range(9);
            if (kind < 5)
                part = plen;
            else if (kind < 7 && plen > 1)
                part = $urandom_range(plen - 1, 1);
            else
                part = 0;
            for (int i = 0; i < part; i++)
            begin
                send_byte(bits[8*i +: 8], $urandom_range(15) == 0);
                sent++;
            end
            // Trailing noise: either a near-miss from the pattern or any byte
            if (part < plen || kind >= 7)
            begin
                for (int i = 0; i < $urandom_range(3, 1); i++)
                begin
                    if ($urandom_range(1))
                        b = bits[8*$urandom_range(plen - 1) +: 8];
                    else
                        b = byte_t'($urandom_range(255));
                    send_byte(b, $urandom_range(15) == 0);
                    sent++;
                end
            end
        end
    endtask

    task automatic test_random_streams();
        int lens [11] = '{1, 2, 3, 16, 0, 31, 4, 7, 17, 8, 2};
        for (int p = 0; p < 11; p++)
        begin
            if (p == 4)
            begin
                send_idle_pct = 72;
                recv_idle_pct = 32;
            end
            else if (p == 8)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            run_stream_phase(LEN_W'(lens[p]), 14);
        end
        // Close the last stream so a final marker is seen in this phase too
        send_byte(byte_t'($urandom_range(255)), 1'b1);
    endtask

    initial
    begin
        rst_n                 <= 1'b0;
        feed_ch.valid         <= 1'b0;
        feed_ch.in_byte       <= '0;
        feed_ch.end_of_stream <= 1'b0;
        cfg_ch.valid          <= 1'b0;
        cfg_ch.index          <= REG_PATTERN_LOW;
        cfg_ch.data           <= '0;
        pat_bits              = '0;
        pat_len               = PATTERN_LENGTH_RESET;
        win_count             = 0;
        mismatches            = 0;
        bytes_taken           = 0;
        results_checked       = 0;
        reg_writes            = 0;
        send_idle_pct         = 32;
        recv_idle_pct         = 72;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_full_length_match();
        test_length_zero();
        test_length_change_midstream();
        test_random_streams();
        wait_idle();

        $display("covered %0d stream bytes, %0d masked results, %0d register writes",
                 bytes_taken, results_checked, reg_writes);
        $display("lengths 0 to 31 incl. clamping, mid-stream length change, flush on end of stream");
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: filelist.f
hdl/spsm_pkg.sv
hdl/spsm_feed_if.sv
hdl/spsm_result_if.sv
hdl/spsm_cfg_if.sv
hdl/spsm_front.sv
hdl/spsm_cmd_fifo.sv
hdl/spsm_back.sv
hdl/stream_pattern_star_masker_unit.sv
sim/stream_pattern_star_masker_unit_tb.sv
